/* hdl/triangle_vertex_dedup_indexer_assert.svh */
// Assertion macros for the triangle vertex de-duplicating indexer.
// Used by the datapath; needs nothing else.
`ifndef TRIANGLE_VERTEX_DEDUP_INDEXER_ASSERT_SVH
`define TRIANGLE_VERTEX_DEDUP_INDEXER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TVDI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TVDI_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tvdi_pkg.sv */
// Shared types and constants for the triangle vertex de-duplicating indexer.
// No dependencies.
package tvdi_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int VERTEX_BITS  = 64;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
  localparam int SUM_W        = COUNT_W + 1;
  localparam int WORD_W       = 64;
  localparam int INDEX_W      = 8;
  localparam int TOTAL_W      = 16;
  localparam int CORNERS      = 3;

  localparam logic [COUNT_W-1:0] STORE_DEPTH  = COUNT_W'(MAX_VERTICES);
  localparam logic [TOTAL_W-1:0] TRI_MAX      = {TOTAL_W{1'b1}};
  localparam logic [1:0]         LAST_CORNER  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_APPEND,
    ST_FINISH,
    ST_REJECT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic append;
    logic finish;
    logic reject;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic fits;
    logic append_last;
  } dp_status_t;

endpackage

/* hdl/tvdi_ctrl.sv */
// Controller for the vertex de-duplicating indexer: sequences scan, room check,
// append and result. Depends on tvdi_pkg.
module tvdi_ctrl
  import tvdi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_done) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = status.fits ? ST_APPEND : ST_REJECT;
      end
      ST_APPEND: begin
        if (status.append_last) state_next = ST_FINISH;
      end
      ST_FINISH: state_next = ST_IDLE;
      ST_REJECT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:   cmd.load   = start;
      ST_SCAN:   cmd.scan   = !status.scan_done;
      ST_CHECK:  cmd        = '0;
      ST_APPEND: cmd.append = 1'b1;
      ST_FINISH: cmd.finish = 1'b1;
      ST_REJECT: cmd.reject = 1'b1;
      default:   cmd        = '0;
    endcase
  end

endmodule

/* hdl/tvdi_datapath.sv */
// Datapath for the vertex de-duplicating indexer: vertex store, scan compare,
// appends, counters and result registers. Depends on tvdi_pkg and the assert macros.
`include "triangle_vertex_dedup_indexer_assert.svh"

module tvdi_datapath
  import tvdi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic [WORD_W-1:0]  vertex_first,
  input  logic [WORD_W-1:0]  vertex_second,
  input  logic [WORD_W-1:0]  vertex_third,
  input  logic               reuse_enable,
  output logic               done,
  output logic [INDEX_W-1:0] index_first,
  output logic [INDEX_W-1:0] index_second,
  output logic [INDEX_W-1:0] index_third,
  output logic               appended_first,
  output logic               appended_second,
  output logic               appended_third,
  output logic               store_full,
  output logic [TOTAL_W-1:0] triangle_total
);

  logic [VERTEX_BITS-1:0] vertex_store [MAX_VERTICES];

  logic [VERTEX_BITS-1:0] corner [CORNERS];
  logic [COUNT_W-1:0]     idx    [CORNERS];
  logic [CORNERS-1:0]     found;
  logic                   reuse;
  logic [COUNT_W-1:0]     base;
  logic [COUNT_W-1:0]     scan_addr;
  logic [COUNT_W-1:0]     rd_idx;
  logic                   rd_valid;
  logic [VERTEX_BITS-1:0] rd_data;
  logic [1:0]             corner_sel;
  logic [COUNT_W-1:0]     vertex_count;
  logic [TOTAL_W-1:0]     triangle_count;
  logic [TOTAL_W-1:0]     triangle_count_next;
  logic [1:0]             need;
  logic [SUM_W-1:0]       need_total;

  assign need       = 2'($countones(~found));
  assign need_total = SUM_W'(base) + SUM_W'(need);

  assign status.scan_done   = !reuse || (scan_addr == base);
  assign status.fits        = (need_total <= SUM_W'(MAX_VERTICES));
  assign status.append_last = (corner_sel == LAST_CORNER);

  assign triangle_count_next = (triangle_count == TRI_MAX) ? triangle_count
                                                           : triangle_count + 1'b1;

  // Store: one read port for the scan, one write port for appends
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data <= vertex_store[scan_addr[ADDR_W-1:0]];
    end
    if (cmd.append && !found[corner_sel]) begin
      vertex_store[vertex_count[ADDR_W-1:0]] <= corner[corner_sel];
    end
  end

  // Per-triangle working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      corner[0]  <= vertex_first[VERTEX_BITS-1:0];
      corner[1]  <= vertex_second[VERTEX_BITS-1:0];
      corner[2]  <= vertex_third[VERTEX_BITS-1:0];
      reuse      <= reuse_enable;
      base       <= vertex_count;
      scan_addr  <= '0;
      corner_sel <= '0;
      found      <= '0;
    end else begin
      if (cmd.scan) begin
        scan_addr <= scan_addr + 1'b1;
      end
      rd_idx <= scan_addr;
      // first match wins: keep a corner once found
      if (rd_valid) begin
        for (int k = 0; k < CORNERS; k++) begin
          if (!found[k] && corner[k] == rd_data) begin
            found[k] <= 1'b1;
            idx[k]   <= rd_idx;
          end
        end
      end
      if (cmd.append) begin
        if (!found[corner_sel]) begin
          idx[corner_sel] <= vertex_count;
        end
        corner_sel <= corner_sel + 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count   <= '0;
      triangle_count <= '0;
      rd_valid       <= 1'b0;
      done           <= 1'b0;
    end else begin
      rd_valid <= cmd.scan;
      done     <= cmd.finish || cmd.reject;
      if (cmd.append && !found[corner_sel]) begin
        vertex_count <= vertex_count + 1'b1;
      end
      if (cmd.finish) begin
        triangle_count <= triangle_count_next;
      end
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      index_first     <= INDEX_W'(idx[0]);
      index_second    <= INDEX_W'(idx[1]);
      index_third     <= INDEX_W'(idx[2]);
      appended_first  <= !found[0];
      appended_second <= !found[1];
      appended_third  <= !found[2];
      store_full      <= 1'b0;
      triangle_total  <= triangle_count_next;
    end else if (cmd.reject) begin
      index_first     <= '0;
      index_second    <= '0;
      index_third     <= '0;
      appended_first  <= 1'b0;
      appended_second <= 1'b0;
      appended_third  <= 1'b0;
      store_full      <= 1'b1;
      triangle_total  <= triangle_count;
    end
  end

  `TVDI_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, vertex_count <= STORE_DEPTH, "vertex count beyond store depth")
  `TVDI_ASSERT_IMP(a_append_room, clk, rst, cmd.append && !found[corner_sel], vertex_count < STORE_DEPTH, "append with store full")
  `TVDI_ASSERT_IMP(a_scan_range, clk, rst, rd_valid, rd_idx < base, "compare outside stored range")
  `TVDI_ASSERT_NXT(a_reject_clean, clk, rst, cmd.reject, done && store_full && !appended_first && !appended_second && !appended_third, "rejected word not clean")

endmodule

/* hdl/triangle_vertex_dedup_indexer.sv */
// Triangle vertex de-duplicating index builder.
// Channels: pulse start with the three vertex words and reuse_enable while busy is low;
// the word is taken at that edge. One result word follows, shown for exactly one cycle
// with done high; the receiver cannot hold it off and must take it then.
// Steps after the accept edge: with reuse_enable set, the stored vertices are read in
// turn, one stored vertex read per cycle from the store's single read port; then a room
// check, three append slots and the result write. With reuse_enable clear nothing is read.
// A rejected triangle (store_full) skips the append slots and returns after the room check.
// busy drops in the same cycle as done, so the next start may be taken at the edge
// that ends the done cycle; a new triangle is not taken before the last one is done.
// The store holds up to 256 vertices.
// Reset (rst, synchronous) empties the store count and the triangle count; store
// contents are not cleared, as only entries below the count are ever read.
// Depends on tvdi_pkg, tvdi_ctrl and tvdi_datapath.
module triangle_vertex_dedup_indexer
  import tvdi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [WORD_W-1:0]  vertex_first,
  input  logic [WORD_W-1:0]  vertex_second,
  input  logic [WORD_W-1:0]  vertex_third,
  input  logic               reuse_enable,
  output logic               done,
  output logic [INDEX_W-1:0] index_first,
  output logic [INDEX_W-1:0] index_second,
  output logic [INDEX_W-1:0] index_third,
  output logic               appended_first,
  output logic               appended_second,
  output logic               appended_third,
  output logic               store_full,
  output logic [TOTAL_W-1:0] triangle_total
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tvdi_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tvdi_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .vertex_first    (vertex_first),
    .vertex_second   (vertex_second),
    .vertex_third    (vertex_third),
    .reuse_enable    (reuse_enable),
    .done            (done),
    .index_first     (index_first),
    .index_second    (index_second),
    .index_third     (index_third),
    .appended_first  (appended_first),
    .appended_second (appended_second),
    .appended_third  (appended_third),
    .store_full      (store_full),
    .triangle_total  (triangle_total)
  );

endmodule
